@@ sv/rtp_pkg.sv @@
package rtp_pkg;

  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 32;
  localparam int CHAN_W  = 8;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [CHAN_W-1:0]  chan_t;

  localparam char_t CHAR_NUL   = 8'h00;
  localparam char_t CHAR_SPACE = 8'h20;
  localparam char_t CHAR_COMMA = 8'h2C;
  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_NINE  = 8'h39;

  localparam int    CHAN_MAX   = 255;
  localparam chan_t ALPHA      = 8'hFF;

endpackage

@@ sv/rtp_if.sv @@
interface rtp_char_if;
  import rtp_pkg::*;

  logic  valid;
  logic  ready;
  char_t character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface rtp_color_if;
  import rtp_pkg::*;

  logic   valid;
  logic   ready;
  color_t color;
  logic   parse_error;

  modport source (output valid, output color, output parse_error, input ready);
  modport sink (input valid, input color, input parse_error, output ready);
endinterface

@@ sv/rgb_triplet_text_parser.sv @@
// Channel  Direction  Payload                    Handshake
// in_if    sink       character[7:0]             valid/ready
// out_if   source     color[31:0], parse_error   valid/ready
//
// One character request is accepted every cycle unless the output is stalled;
// it passes an input register and the parse step, and any result is held in an
// output register; a result becomes valid once its terminating character has passed both.
// The rate is set by the parse step with its multiply by ten.
// Reset is synchronous and active low and restarts the parse.
// A stalled output holds its result and backs up the input register.
module rgb_triplet_text_parser (
  input  logic        clk,
  input  logic        rst_n,
  rtp_char_if.sink    in_if,
  rtp_color_if.source out_if
);
  import rtp_pkg::*;

  rtp_char_if stage_if ();

  rtp_in_reg u_in_reg (
    .clk  (clk),
    .rst_n(rst_n),
    .up   (in_if),
    .down (stage_if.source)
  );

  rtp_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .up   (stage_if.sink),
    .down (out_if)
  );

endmodule

@@ sv/rtp_in_reg.sv @@
module rtp_in_reg (
  input  logic        clk,
  input  logic        rst_n,
  rtp_char_if.sink    up,
  rtp_char_if.source  down
);
  import rtp_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  char_t char_r;

  assign up.ready       = !valid_r || down.ready;
  assign down.valid     = valid_r;
  assign down.character = char_r;

  always_comb begin
    valid_nxt = valid_r;
    if (up.ready) begin
      valid_nxt = up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (up.valid && up.ready) begin
      char_r <= up.character;
    end
  end

endmodule

@@ sv/rtp_core.sv @@
module rtp_core (
  input  logic        clk,
  input  logic        rst_n,
  rtp_char_if.sink    up,
  rtp_color_if.source down
);
  import rtp_pkg::*;

  typedef enum logic [1:0] {
    PH_SKIP  = 2'd0,
    PH_START = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [1:0]   idx_r, idx_nxt;
  chan_t        val_r, val_nxt;
  logic [15:0]  packed_r, packed_nxt;
  logic         out_valid_r, out_valid_nxt;
  color_t       color_r, color_nxt;
  logic         err_r, err_nxt;

  logic         advance;
  logic         char_is_num;
  logic         is_skip;
  logic         in_leading;
  chan_t        digit_val;
  logic [11:0]  val_x10;

  assign up.ready         = !out_valid_r || down.ready;
  assign advance          = up.valid && up.ready;
  assign down.valid       = out_valid_r;
  assign down.color       = color_r;
  assign down.parse_error = err_r;

  assign char_is_num = (up.character >= CHAR_ZERO) && (up.character <= CHAR_NINE);
  assign is_skip     = (up.character != CHAR_NUL) && (up.character <= CHAR_SPACE);
  assign in_leading  = (phase_r != PH_START) && (phase_r != PH_DIGIT);
  assign digit_val   = up.character - CHAR_ZERO;
  assign val_x10     = {1'b0, val_r, 3'b000} + {3'b000, val_r, 1'b0}
                       + {4'b0000, digit_val};

  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    packed_nxt    = packed_r;
    out_valid_nxt = out_valid_r && !down.ready;
    color_nxt     = color_r;
    err_nxt       = err_r;
    if (advance) begin
      if (in_leading && is_skip) begin
        phase_nxt = PH_SKIP;
      end else if (in_leading || phase_r == PH_START) begin
        if (!char_is_num) begin
          out_valid_nxt = 1'b1;
          color_nxt     = '0;
          err_nxt       = 1'b1;
        end else begin
          val_nxt   = digit_val;
          phase_nxt = PH_DIGIT;
        end
      end else if (char_is_num) begin
        if (val_x10 > 12'(CHAN_MAX)) begin
          out_valid_nxt = 1'b1;
          color_nxt     = '0;
          err_nxt       = 1'b1;
        end else begin
          val_nxt = val_x10[CHAN_W-1:0];
        end
      end else if (!idx_r[1]) begin
        if (up.character != CHAR_COMMA) begin
          out_valid_nxt = 1'b1;
          color_nxt     = '0;
          err_nxt       = 1'b1;
        end else begin
          packed_nxt = {packed_r[7:0], val_r};
          idx_nxt    = idx_r + 2'd1;
          val_nxt    = '0;
          phase_nxt  = PH_START;
        end
      end else begin
        out_valid_nxt = 1'b1;
        color_nxt     = {packed_r, val_r, ALPHA};
        err_nxt       = 1'b0;
      end
      // Every result restarts the parse for the next color.
      if (out_valid_nxt && !(out_valid_r && !down.ready)) begin
        phase_nxt  = PH_SKIP;
        idx_nxt    = '0;
        val_nxt    = '0;
        packed_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SKIP;
      idx_r       <= '0;
      val_r       <= '0;
      packed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      val_r       <= val_nxt;
      packed_r    <= packed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    color_r <= color_nxt;
    err_r   <= err_nxt;
  end

endmodule

@@ verif/rgb_triplet_text_parser_checker.sv @@
`timescale 1ns / 100ps

module rgb_triplet_text_parser_checker
  import rtp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  rtp_char_if   char_mon,
  rtp_color_if  color_mon,
  output int    fail_count,
  output int    pending,
  output int    color_count,
  output int    error_count
);

  typedef enum logic [1:0] {
    PH_SKIP  = 2'd0,
    PH_START = 2'd1,
    PH_DIGIT = 2'd2
  } parse_phase_t;

  typedef struct packed {
    color_t color;
    logic   parse_error;
  } color_result_t;

  color_result_t expected_colors[$];
  color_result_t want;

  parse_phase_t phase;
  logic [1:0]   chan_idx;
  logic [8:0]   chan_val;
  logic [23:0]  rgb_so_far;

  task automatic restart_parse();
    phase      = PH_SKIP;
    chan_idx   = 2'd0;
    chan_val   = 9'd0;
    rgb_so_far = 24'd0;
  endtask

  task automatic parse_char(input char_t c);
    logic          char_is_num;
    bit            have_result;
    int            v;
    color_result_t r;
    char_is_num   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    have_result   = 1'b0;
    r.color       = '0;
    r.parse_error = 1'b0;
    if (phase != PH_START && phase != PH_DIGIT) begin
      if (c != CHAR_NUL && c <= CHAR_SPACE) return;
      phase = PH_START;
    end
    if (phase == PH_START) begin
      if (!char_is_num) begin
        have_result   = 1'b1;
        r.parse_error = 1'b1;
      end else begin
        chan_val = 9'(c - CHAR_ZERO);
        phase    = PH_DIGIT;
      end
    end else if (char_is_num) begin
      v = int'(chan_val) * 10 + int'(c - CHAR_ZERO);
      if (v > CHAN_MAX) begin
        have_result   = 1'b1;
        r.parse_error = 1'b1;
      end else begin
        chan_val = v[8:0];
      end
    end else if (chan_idx < 2'd2) begin
      if (c != CHAR_COMMA) begin
        have_result   = 1'b1;
        r.parse_error = 1'b1;
      end else begin
        rgb_so_far = {rgb_so_far[15:0], chan_val[7:0]};
        chan_idx   = chan_idx + 2'd1;
        chan_val   = 9'd0;
        phase      = PH_START;
      end
    end else begin
      have_result = 1'b1;
      r.color     = {rgb_so_far[15:0], chan_val[7:0], ALPHA};
    end
    if (have_result) begin
      expected_colors.push_back(r);
      restart_parse();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_parse();
      expected_colors.delete();
      fail_count  = 0;
      color_count = 0;
      error_count = 0;
    end else begin
      if (char_mon.valid && char_mon.ready) begin
        parse_char(char_mon.character);
      end
      if (color_mon.valid && color_mon.ready) begin
        if (expected_colors.size() == 0) begin
          $error("unexpected result: color %h, parse_error %b",
                 color_mon.color, color_mon.parse_error);
          fail_count++;
        end else begin
          want = expected_colors.pop_front();
          if (color_mon.color !== want.color) begin
            $error("color: expected %h, actual %h", want.color, color_mon.color);
            fail_count++;
          end
          if (color_mon.parse_error !== want.parse_error) begin
            $error("parse_error: expected %b, actual %b",
                   want.parse_error, color_mon.parse_error);
            fail_count++;
          end
          if (want.parse_error) error_count++;
          else color_count++;
        end
      end
    end
    pending = expected_colors.size();
  end

endmodule

@@ verif/rgb_triplet_text_parser_test.sv @@
`timescale 1ns / 100ps

module rgb_triplet_text_parser_test;
  import rtp_pkg::*;

  localparam int NUM_CHARS      = 1350;
  localparam int CALM_CHARS     = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rtp_char_if  char_if ();
  rtp_color_if color_if ();

  int    fail_count;
  int    pending;
  int    color_count;
  int    error_count;
  bit    idle_on;
  int    stall_left;
  int    chars_sent;
  int    quiet_cycles;
  char_t text_q[$];

  always #4 clk = ~clk;

  rgb_triplet_text_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (char_if),
    .out_if (color_if)
  );

  rgb_triplet_text_parser_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_mon    (char_if),
    .color_mon   (color_if),
    .fail_count  (fail_count),
    .pending     (pending),
    .color_count (color_count),
    .error_count (error_count)
  );

  always @(negedge clk) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    if (stall_left > 0) begin
      color_if.ready <= 1'b0;
      stall_left--;
    end else begin
      color_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((char_if.valid && char_if.ready) || (color_if.valid && color_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_char(input char_t c);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_if.valid     <= 1'b1;
    char_if.character <= c;
    @(posedge clk);
    while (!char_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text();
    while (text_q.size() > 0) begin
      send_char(text_q.pop_front());
      chars_sent++;
    end
  endtask

  task automatic wait_all_results();
    char_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back(char_t'(s[i]));
  endtask

  task automatic add_channel(input bit over);
    int v;
    int zeros;
    if (over) begin
      v = $urandom_range(256, 999);
    end else begin
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = CHAN_MAX;
        default: v = $urandom_range(0, CHAN_MAX);
      endcase
    end
    zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (zeros) text_q.push_back(CHAR_ZERO);
    if (v >= 100) text_q.push_back(CHAR_ZERO + char_t'(v / 100));
    if (v >= 10) text_q.push_back(CHAR_ZERO + char_t'((v / 10) % 10));
    text_q.push_back(CHAR_ZERO + char_t'(v % 10));
  endtask

  task automatic build_request();
    int    kind;
    int    bad_chan;
    int    pos;
    int    i;
    char_t c;
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      repeat ($urandom_range(0, 2)) text_q.push_back(char_t'($urandom_range(1, 32)));
      bad_chan = (kind == 6) ? $urandom_range(0, 2) : 3;
      for (i = 0; i < 3; i++) begin
        if (i > 0) text_q.push_back(CHAR_COMMA);
        add_channel(i == bad_chan);
      end
      do c = char_t'($urandom_range(0, 255)); while (c >= CHAR_ZERO && c <= CHAR_NINE);
      text_q.push_back(c);
      if (kind == 7) begin
        pos = $urandom_range(0, text_q.size() - 1);
        text_q[pos] = char_t'($urandom_range(0, 255));
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0: c = CHAR_ZERO + char_t'($urandom_range(0, 9));
          1: c = CHAR_COMMA;
          2: c = CHAR_SPACE;
          default: c = char_t'($urandom_range(0, 255));
        endcase
        text_q.push_back(c);
      end
    end
  endtask

  initial begin
    char_if.valid     = 1'b0;
    char_if.character = CHAR_NUL;
    color_if.ready    = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n   <= 1'b1;
    idle_on  = 1'b1;

    // Skipped leading bytes, extreme channel values and a comma as terminator.
    text_q.push_back(8'h01);
    text_q.push_back(CHAR_SPACE);
    add_text("255,0,9,");
    // NUL is malformed, not skipped.
    text_q.push_back(CHAR_NUL);
    // A space after a comma is a bad channel start.
    add_text("2, ");
    // Overflow on the digit that goes past 255, then a missing separator.
    add_text("256");
    add_text("1;");
    // A high byte where a channel must begin.
    text_q.push_back(8'hFF);
    // Leading zeros, with a high byte as terminator.
    add_text("00,7,3");
    text_q.push_back(8'hFF);
    send_text();
    wait_all_results();

    while (chars_sent < NUM_CHARS) begin
      idle_on = (chars_sent < NUM_CHARS - CALM_CHARS) && ($urandom_range(0, 3) != 0);
      build_request();
      send_text();
      if ($urandom_range(0, 24) == 0) wait_all_results();
    end
    idle_on = 1'b0;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d characters; checked %0d colors and %0d parse errors.",
             chars_sent, color_count, error_count);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
